### rtl/sssd_pkg.sv
// Shared types and constants for the shortest-distance core.
`timescale 1ns / 1ps
`default_nettype none

package sssd_pkg;

  localparam int ID_W     = 6;
  localparam int DIST_W   = 32;
  localparam int ID_SPACE = 64;

  localparam logic [DIST_W-1:0] DIST_INF = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;
  localparam logic [ID_W-1:0]   SRC_NONE = 6'h3F;

  // One stored directed edge
  typedef struct packed {
    logic [ID_W-1:0]          tail;
    logic [ID_W-1:0]          head;
    logic signed [DIST_W-1:0] weight;
  } edge_t;

  // Load request into the graph store
  typedef struct packed {
    logic            en;
    logic            mode;
    logic [ID_W-1:0] vid;
    edge_t           arc;
  } load_req_t;

  // Distance table write
  typedef struct packed {
    logic              en;
    logic [ID_W-1:0]   addr;
    logic [DIST_W-1:0] dist_val;
    logic [ID_W-1:0]   pred;
  } dist_wr_t;

  // Distance table read data; valid means a finite distance
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] dist_val;
    logic [ID_W-1:0]   pred;
  } dist_rd_t;

  // Operands of the relaxation unit
  typedef struct packed {
    logic              tail_ok;
    logic [DIST_W-1:0] d_tail;
    logic [DIST_W-1:0] weight;
    logic              head_valid;
    logic [DIST_W-1:0] d_head;
  } alu_req_t;

  // Registered relaxation outcome
  typedef struct packed {
    logic              update;
    logic [DIST_W-1:0] dist_val;
  } alu_res_t;

endpackage

`default_nettype wire

### rtl/single_source_shortest_distances_core.sv
// Top level: load sequencer, relaxation rounds and result output.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in_     | input     | in_valid/in_stall  | mode, vertex_id, edge_source/target/weight,
//          |           |                    | last_item
//  out_    | output    | out_valid/out_stall| out_vertex, reachable, distance,
//          |           |                    | predecessor, last_result
//
// Load items are taken one per cycle while in_stall is low. After the last item: a setup
// state, then per edge per round the steps edge read, table read, add/compare, write-back,
// for up to vertex_count-1 rounds, then per result address, table read, capture and wait.
// The single add/compare unit and the shared table ports make these steps run in turn.
// Reset (rst_n low, synchronous) empties the load and idles the output.
// in_stall is high from the last item until the final result is taken.
`timescale 1ns / 1ps
`default_nettype none

module single_source_shortest_distances_core #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_mode,
  input  wire [sssd_pkg::ID_W-1:0]            in_vertex_id,
  input  wire [sssd_pkg::ID_W-1:0]            in_edge_source,
  input  wire [sssd_pkg::ID_W-1:0]            in_edge_target,
  input  wire signed [sssd_pkg::DIST_W-1:0]   in_edge_weight,
  input  wire                                 in_last_item,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [sssd_pkg::ID_W-1:0]           out_vertex,
  output logic                                out_reachable,
  output logic signed [sssd_pkg::DIST_W-1:0]  out_distance,
  output logic [sssd_pkg::ID_W-1:0]           out_predecessor,
  output logic                                out_last_result
);

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_E_ADDR = 4'd2;
  localparam logic [3:0] S_E_TBL  = 4'd3;
  localparam logic [3:0] S_E_ALU  = 4'd4;
  localparam logic [3:0] S_E_WR   = 4'd5;
  localparam logic [3:0] S_O_ADDR = 4'd6;
  localparam logic [3:0] S_O_TBL  = 4'd7;
  localparam logic [3:0] S_O_CAP  = 4'd8;
  localparam logic [3:0] S_O_WAIT = 4'd9;

  logic [3:0]                    state_r, state_nxt;
  logic [EIDX_W-1:0]             e_r, e_nxt;
  logic [VCNT_W-1:0]             rnd_r, rnd_nxt;
  logic [VIDX_W-1:0]             k_r, k_nxt;
  logic                          changed_r, changed_nxt;

  sssd_pkg::load_req_t           load;
  logic                          g_clear;
  logic [sssd_pkg::ID_W-1:0]     vlist_rdata;
  sssd_pkg::edge_t               edge_rdata;
  logic [VCNT_W-1:0]             vcount;
  logic [ECNT_W-1:0]             ecount;
  logic [sssd_pkg::ID_SPACE-1:0] loaded;
  logic [sssd_pkg::ID_W-1:0]     source;

  logic                          t_clear;
  sssd_pkg::dist_wr_t            t_wr;
  logic [sssd_pkg::ID_W-1:0]     rd_a_addr;
  sssd_pkg::dist_rd_t            rd_a, rd_b;
  sssd_pkg::alu_req_t            alu_req;
  sssd_pkg::alu_res_t            alu_res;

  logic                          out_valid_r;
  logic [sssd_pkg::ID_W-1:0]     out_vertex_r, out_pred_r;
  logic                          out_reach_r, out_last_r;
  logic [sssd_pkg::DIST_W-1:0]   out_dist_r;

  logic                          in_acc, out_acc;
  logic                          more_edges, more_rounds, is_last_k;
  logic                          cap_reach;

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  // Load request
  always_comb begin
    load.en         = in_acc;
    load.mode       = in_mode;
    load.vid        = in_vertex_id;
    load.arc.tail   = in_edge_source;
    load.arc.head   = in_edge_target;
    load.arc.weight = in_edge_weight;
  end

  sssd_graph_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_graph (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .clear       (g_clear),
    .vlist_raddr (k_r),
    .vlist_rdata (vlist_rdata),
    .edge_raddr  (e_r),
    .edge_rdata  (edge_rdata),
    .vcount      (vcount),
    .ecount      (ecount),
    .loaded      (loaded),
    .source      (source)
  );

  // Table port A follows the edge tail in rounds and the vertex list on output
  assign rd_a_addr = (state_r == S_O_TBL || state_r == S_O_CAP) ? vlist_rdata
                                                               : edge_rdata.tail;

  sssd_dist_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_all (t_clear),
    .wr        (t_wr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (edge_rdata.head),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // Operands: both ends loaded and tail finite
  always_comb begin
    alu_req.tail_ok    = loaded[edge_rdata.tail] && loaded[edge_rdata.head] && rd_a.valid;
    alu_req.d_tail     = rd_a.dist_val;
    alu_req.weight     = edge_rdata.weight;
    alu_req.head_valid = rd_b.valid;
    alu_req.d_head     = rd_b.dist_val;
  end

  sssd_relax_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .res (alu_res)
  );

  // Table writes: source seed at setup, improvements at write-back
  always_comb begin
    t_clear       = (state_r == S_INIT);
    t_wr.en       = 1'b0;
    t_wr.addr     = edge_rdata.head;
    t_wr.dist_val = alu_res.dist_val;
    t_wr.pred     = edge_rdata.tail;
    if (state_r == S_INIT) begin
      t_wr.en       = 1'b1;
      t_wr.addr     = source;
      t_wr.dist_val = '0;
      t_wr.pred     = source;
    end else if (state_r == S_E_WR) begin
      t_wr.en = alu_res.update;
    end
  end

  assign more_edges  = ((ECNT_W + 1)'(e_r) + (ECNT_W + 1)'(1)) < (ECNT_W + 1)'(ecount);
  assign more_rounds = ((VCNT_W + 1)'(rnd_r) + (VCNT_W + 1)'(2)) < (VCNT_W + 1)'(vcount);
  assign is_last_k   = (VCNT_W'(k_r) + VCNT_W'(1)) == vcount;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    e_nxt       = e_r;
    rnd_nxt     = rnd_r;
    k_nxt       = k_r;
    changed_nxt = changed_r;
    g_clear     = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_acc && in_last_item) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        e_nxt       = '0;
        rnd_nxt     = '0;
        k_nxt       = '0;
        changed_nxt = 1'b0;
        if (vcount == '0) begin
          g_clear   = 1'b1;
          state_nxt = S_LOAD;
        end else if (vcount > VCNT_W'(1) && ecount != '0) begin
          state_nxt = S_E_ADDR;
        end else begin
          state_nxt = S_O_ADDR;
        end
      end
      S_E_ADDR: state_nxt = S_E_TBL;
      S_E_TBL:  state_nxt = S_E_ALU;
      S_E_ALU:  state_nxt = S_E_WR;
      S_E_WR: begin
        if (more_edges) begin
          e_nxt       = e_r + EIDX_W'(1);
          changed_nxt = changed_r | alu_res.update;
          state_nxt   = S_E_ADDR;
        end else if ((changed_r | alu_res.update) && more_rounds) begin
          e_nxt       = '0;
          rnd_nxt     = rnd_r + VCNT_W'(1);
          changed_nxt = 1'b0;
          state_nxt   = S_E_ADDR;
        end else begin
          state_nxt = S_O_ADDR;
        end
      end
      S_O_ADDR: state_nxt = S_O_TBL;
      S_O_TBL:  state_nxt = S_O_CAP;
      S_O_CAP:  state_nxt = S_O_WAIT;
      S_O_WAIT: begin
        if (out_acc) begin
          if (out_last_r) begin
            g_clear   = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + VIDX_W'(1);
            state_nxt = S_O_ADDR;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      e_r       <= '0;
      rnd_r     <= '0;
      k_r       <= '0;
      changed_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      e_r       <= e_nxt;
      rnd_r     <= rnd_nxt;
      k_r       <= k_nxt;
      changed_r <= changed_nxt;
    end
  end

  // Result register
  assign cap_reach = rd_a.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_O_CAP) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_O_CAP) begin
      out_vertex_r <= vlist_rdata;
      out_reach_r  <= cap_reach;
      out_dist_r   <= cap_reach ? rd_a.dist_val : sssd_pkg::DIST_INF;
      // the source always names itself, unreachable names vertex zero
      out_pred_r   <= !cap_reach ? '0 :
                      (vlist_rdata == source) ? source : rd_a.pred;
      out_last_r   <= is_last_k;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_vertex      = out_vertex_r;
  assign out_reachable   = out_reach_r;
  assign out_distance    = out_dist_r;
  assign out_predecessor = out_pred_r;
  assign out_last_result = out_last_r;

  // No load item is taken while a result is pending
  a_no_load_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && out_valid_r))
    else $error("input accepted while a result is pending");

  // Edge index stays inside the loaded edges
  a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_E_ADDR) |-> ((ECNT_W + 1)'(e_r) < (ECNT_W + 1)'(ecount)))
    else $error("edge index beyond edge count");

  // Load is emptied once the final result is taken
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_r) |=> (vcount == '0 && ecount == '0 && state_r == S_LOAD))
    else $error("load not cleared after final result");

endmodule

`default_nettype wire

### rtl/sssd_graph_store.sv
// Vertex list, edge store, load counters, loaded flags and source tracking.
`timescale 1ns / 1ps
`default_nettype none

module sssd_graph_store #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  localparam int VIDX_W = $clog2(MAX_VERTICES),
  localparam int VCNT_W = $clog2(MAX_VERTICES + 1),
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int ECNT_W = $clog2(MAX_EDGES + 1)
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  sssd_pkg::load_req_t            load,
  input  wire                            clear,
  input  wire [VIDX_W-1:0]               vlist_raddr,
  output logic [sssd_pkg::ID_W-1:0]      vlist_rdata,
  input  wire [EIDX_W-1:0]               edge_raddr,
  output sssd_pkg::edge_t                edge_rdata,
  output logic [VCNT_W-1:0]              vcount,
  output logic [ECNT_W-1:0]              ecount,
  output logic [sssd_pkg::ID_SPACE-1:0]  loaded,
  output logic [sssd_pkg::ID_W-1:0]      source
);

  logic [sssd_pkg::ID_W-1:0]     vlist_mem_r [MAX_VERTICES];
  sssd_pkg::edge_t               edge_mem_r  [MAX_EDGES];
  logic [sssd_pkg::ID_W-1:0]     vlist_rdata_r;
  sssd_pkg::edge_t               edge_rdata_r;

  logic [VCNT_W-1:0]             vcount_r, vcount_nxt;
  logic [ECNT_W-1:0]             ecount_r, ecount_nxt;
  logic [sssd_pkg::ID_SPACE-1:0] loaded_r, loaded_nxt;
  logic [sssd_pkg::ID_W-1:0]     src_r, src_nxt;
  logic                          v_wr, e_wr;

  // Items beyond a full store are dropped
  assign v_wr = load.en && !load.mode && (vcount_r < VCNT_W'(MAX_VERTICES));
  assign e_wr = load.en &&  load.mode && (ecount_r < ECNT_W'(MAX_EDGES));

  // Counters, flags and running minimum id
  always_comb begin
    vcount_nxt = vcount_r;
    ecount_nxt = ecount_r;
    loaded_nxt = loaded_r;
    src_nxt    = src_r;
    if (clear) begin
      vcount_nxt = '0;
      ecount_nxt = '0;
      loaded_nxt = '0;
      src_nxt    = sssd_pkg::SRC_NONE;
    end else begin
      if (v_wr) begin
        vcount_nxt           = vcount_r + VCNT_W'(1);
        loaded_nxt[load.vid] = 1'b1;
        if (load.vid < src_r) begin
          src_nxt = load.vid;
        end
      end
      if (e_wr) begin
        ecount_nxt = ecount_r + ECNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      ecount_r <= '0;
      loaded_r <= '0;
      src_r    <= sssd_pkg::SRC_NONE;
    end else begin
      vcount_r <= vcount_nxt;
      ecount_r <= ecount_nxt;
      loaded_r <= loaded_nxt;
      src_r    <= src_nxt;
    end
  end

  // Memories: one write port each, registered read
  always_ff @(posedge clk) begin
    if (v_wr) begin
      vlist_mem_r[vcount_r[VIDX_W-1:0]] <= load.vid;
    end
    if (e_wr) begin
      edge_mem_r[ecount_r[EIDX_W-1:0]] <= load.arc;
    end
    vlist_rdata_r <= vlist_mem_r[vlist_raddr];
    edge_rdata_r  <= edge_mem_r[edge_raddr];
  end

  assign vlist_rdata = vlist_rdata_r;
  assign edge_rdata  = edge_rdata_r;
  assign vcount      = vcount_r;
  assign ecount      = ecount_r;
  assign loaded      = loaded_r;
  assign source      = src_r;

endmodule

`default_nettype wire

### rtl/sssd_dist_table.sv
// Per-vertex distance and predecessor memories with finite-distance flags.
`timescale 1ns / 1ps
`default_nettype none

module sssd_dist_table (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        clear_all,
  input  sssd_pkg::dist_wr_t         wr,
  input  wire [sssd_pkg::ID_W-1:0]   rd_a_addr,
  input  wire [sssd_pkg::ID_W-1:0]   rd_b_addr,
  output sssd_pkg::dist_rd_t         rd_a,
  output sssd_pkg::dist_rd_t         rd_b
);

  logic [sssd_pkg::DIST_W-1:0]   dist_mem_r [sssd_pkg::ID_SPACE];
  logic [sssd_pkg::ID_W-1:0]     pred_mem_r [sssd_pkg::ID_SPACE];
  logic [sssd_pkg::ID_SPACE-1:0] valid_r, valid_nxt;
  sssd_pkg::dist_rd_t            rd_a_r, rd_b_r;

  // Finite flags: a cleared entry reads as infinite
  always_comb begin
    valid_nxt = valid_r;
    if (clear_all) begin
      valid_nxt = '0;
    end
    if (wr.en) begin
      valid_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Storage, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr.en) begin
      dist_mem_r[wr.addr] <= wr.dist_val;
      pred_mem_r[wr.addr] <= wr.pred;
    end
    rd_a_r.valid    <= valid_r[rd_a_addr];
    rd_a_r.dist_val <= dist_mem_r[rd_a_addr];
    rd_a_r.pred     <= pred_mem_r[rd_a_addr];
    rd_b_r.valid    <= valid_r[rd_b_addr];
    rd_b_r.dist_val <= dist_mem_r[rd_b_addr];
    rd_b_r.pred     <= pred_mem_r[rd_b_addr];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

`default_nettype wire

### rtl/sssd_relax_alu.sv
// Shared relaxation unit: widened add, saturation and compare, registered.
`timescale 1ns / 1ps
`default_nettype none

module sssd_relax_alu (
  input  wire                 clk,
  input  sssd_pkg::alu_req_t  req,
  output sssd_pkg::alu_res_t  res
);

  logic signed [sssd_pkg::DIST_W:0] sum, sat, head_eff;
  logic                             below;
  sssd_pkg::alu_res_t               res_r;

  // Candidate distance through the tail, one bit wider
  always_comb begin
    sum = {req.d_tail[sssd_pkg::DIST_W-1], req.d_tail}
        + {req.weight[sssd_pkg::DIST_W-1], req.weight};
    // under the minimum: sign bits disagree with a negative sum
    below    = sum[sssd_pkg::DIST_W] & ~sum[sssd_pkg::DIST_W-1];
    sat      = below ? {1'b1, sssd_pkg::DIST_MIN} : sum;
    head_eff = req.head_valid ? {req.d_head[sssd_pkg::DIST_W-1], req.d_head}
                              : {1'b0, sssd_pkg::DIST_INF};
  end

  always_ff @(posedge clk) begin
    res_r.update   <= req.tail_ok && (sat < head_eff);
    res_r.dist_val <= sat[sssd_pkg::DIST_W-1:0];
  end

  assign res = res_r;

endmodule

`default_nettype wire
